// File: rtl/csv_decimal_line_parser_core_defines.svh
// ---------------------------------------------------------------------------
// CSV decimal line parser: assertion macros
// Shared checking macros for the parser core.
// ---------------------------------------------------------------------------
`ifndef CSV_DECIMAL_LINE_PARSER_CORE_DEFINES_SVH
`define CSV_DECIMAL_LINE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CDLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cdlp_pkg.sv
// ---------------------------------------------------------------------------
// CSV decimal line parser package
// Sizes, character codes and the command word passed from front to back.
// ---------------------------------------------------------------------------
package cdlp_pkg;

  // Line and field geometry.
  localparam int LINE_CAPACITY = 40;
  localparam int FIELD_COUNT   = 5;
  localparam int OUT_FIELDS    = 5;
  localparam int SHOWN_FIELDS  = (FIELD_COUNT < OUT_FIELDS) ? FIELD_COUNT : OUT_FIELDS;

  localparam int LINE_LEN_W  = $clog2(LINE_CAPACITY);
  localparam int FIELD_CNT_W = $clog2(FIELD_COUNT + 1);
  localparam int VALUE_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int DIGIT_W     = 4;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'd44;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'd0;

  // Operations the back end carries out.
  typedef enum logic [1:0] {
    CMD_DIGIT,
    CMD_CLOSE,
    CMD_RESTART,
    CMD_TERM
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [DIGIT_W-1:0]   digit;
  } cmd_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_LVL_W-1:0] level;
  } queue_status_t;

endpackage

// File: rtl/cdlp_stream_if.sv
// ---------------------------------------------------------------------------
// CSV decimal line parser channels
// Byte input channel and five-value result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface cdlp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [cdlp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cdlp_result_if;
  logic                         valid;
  logic                         ready;
  logic [cdlp_pkg::VALUE_W-1:0] value_a;
  logic [cdlp_pkg::VALUE_W-1:0] value_b;
  logic [cdlp_pkg::VALUE_W-1:0] value_c;
  logic [cdlp_pkg::VALUE_W-1:0] value_d;
  logic [cdlp_pkg::VALUE_W-1:0] value_e;

  modport source (output valid, output value_a, output value_b, output value_c,
                  output value_d, output value_e, input ready);
  modport sink (input valid, input value_a, input value_b, input value_c,
                input value_d, input value_e, output ready);
endinterface

// File: rtl/cdlp_front.sv
// ---------------------------------------------------------------------------
// CSV decimal line parser front end
// Accepts bytes, tracks line length and turns digits, closers, terminators and overflows into commands.
// ---------------------------------------------------------------------------
module cdlp_front (
  input  logic                    clk,
  input  logic                    rst,
  cdlp_byte_if.sink               rx,
  input  cdlp_pkg::queue_status_t status,
  output logic                    push,
  output cdlp_pkg::cmd_t          push_cmd
);

  logic [cdlp_pkg::LINE_LEN_W-1:0] line_length;
  logic [cdlp_pkg::LINE_LEN_W-1:0] line_length_next;
  logic                            accept;
  logic                            is_term;
  logic                            is_digit;
  logic                            is_close;
  logic                            has_room;
  logic [cdlp_pkg::BYTE_W-1:0]     digit_full;

  // A byte word is taken whenever the queue can hold one more command.
  assign rx.ready = !status.full;
  assign accept   = rx.valid && rx.ready;

  // Classify the byte.
  assign is_term    = (rx.rx_byte == cdlp_pkg::CHAR_LF) || (rx.rx_byte == cdlp_pkg::CHAR_CR);
  assign is_digit   = (rx.rx_byte >= cdlp_pkg::CHAR_ZERO) && (rx.rx_byte <= cdlp_pkg::CHAR_NINE);
  assign is_close   = (rx.rx_byte == cdlp_pkg::CHAR_COMMA) || (rx.rx_byte == cdlp_pkg::CHAR_NUL);
  assign has_room   = line_length < cdlp_pkg::LINE_LEN_W'(cdlp_pkg::LINE_CAPACITY - 1);
  assign digit_full = rx.rx_byte - cdlp_pkg::CHAR_ZERO;

  // Build the command and the next line length. Other characters only count.
  always_comb begin
    line_length_next  = line_length;
    push              = 1'b0;
    push_cmd.op       = cdlp_pkg::CMD_DIGIT;
    push_cmd.digit    = digit_full[cdlp_pkg::DIGIT_W-1:0];
    if (accept) begin
      if (is_term) begin
        line_length_next = '0;
        push             = 1'b1;
        push_cmd.op      = cdlp_pkg::CMD_TERM;
      end else if (has_room) begin
        line_length_next = line_length + 1'b1;
        if (is_digit) begin
          push        = 1'b1;
          push_cmd.op = cdlp_pkg::CMD_DIGIT;
        end else if (is_close) begin
          push        = 1'b1;
          push_cmd.op = cdlp_pkg::CMD_CLOSE;
        end
      end else begin
        // Line overflow: drop the byte and start over.
        line_length_next = '0;
        push             = 1'b1;
        push_cmd.op      = cdlp_pkg::CMD_RESTART;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
    end else begin
      line_length <= line_length_next;
    end
  end

endmodule

// File: rtl/cdlp_queue.sv
// ---------------------------------------------------------------------------
// CSV decimal line parser command queue
// Short first-in first-out buffer that decouples front and back ends.
// ---------------------------------------------------------------------------
module cdlp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  cdlp_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output cdlp_pkg::cmd_t          head,
  output cdlp_pkg::queue_status_t status
);

  cdlp_pkg::cmd_t                   entries [cdlp_pkg::QUEUE_DEPTH];
  logic [cdlp_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [cdlp_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [cdlp_pkg::QUEUE_LVL_W-1:0] level;
  logic                             do_push;
  logic                             do_pop;

  assign status.level = level;
  assign status.full  = (level == cdlp_pkg::QUEUE_LVL_W'(cdlp_pkg::QUEUE_DEPTH));
  assign status.empty = (level == '0);
  assign head         = entries[rd_ptr];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// File: rtl/cdlp_back.sv
// ---------------------------------------------------------------------------
// CSV decimal line parser back end
// Executes commands: accumulates digits, fills field slots, emits results.
// ---------------------------------------------------------------------------
module cdlp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  cdlp_pkg::cmd_t          head,
  input  cdlp_pkg::queue_status_t status,
  output logic                    pop,
  cdlp_result_if.source           result
);

  logic [cdlp_pkg::VALUE_W-1:0]     accumulator;
  logic [cdlp_pkg::VALUE_W-1:0]     accumulator_next;
  logic [cdlp_pkg::FIELD_CNT_W-1:0] fields_done;
  logic [cdlp_pkg::FIELD_CNT_W-1:0] fields_done_next;
  logic [cdlp_pkg::VALUE_W-1:0]     field_store [cdlp_pkg::FIELD_COUNT];
  logic [cdlp_pkg::VALUE_W-1:0]     field_store_next [cdlp_pkg::FIELD_COUNT];
  logic [cdlp_pkg::VALUE_W-1:0]     shown [cdlp_pkg::OUT_FIELDS];
  logic [cdlp_pkg::VALUE_W-1:0]     values [cdlp_pkg::OUT_FIELDS];
  logic                             out_free;
  logic                             emit;
  logic                             slot_free;
  logic                             line_full;

  // The output register can load when it is empty or its word leaves now.
  assign out_free  = !result.valid || result.ready;
  assign slot_free = fields_done < cdlp_pkg::FIELD_CNT_W'(cdlp_pkg::FIELD_COUNT);
  assign line_full = fields_done >= cdlp_pkg::FIELD_CNT_W'(cdlp_pkg::FIELD_COUNT - 1);

  // Command execution.
  always_comb begin
    accumulator_next = accumulator;
    fields_done_next = fields_done;
    field_store_next = field_store;
    pop              = 1'b0;
    emit             = 1'b0;
    if (!status.empty) begin
      unique case (head.op)
        cdlp_pkg::CMD_DIGIT: begin
          pop              = 1'b1;
          accumulator_next = (accumulator << 3) + (accumulator << 1)
                             + cdlp_pkg::VALUE_W'(head.digit);
        end
        cdlp_pkg::CMD_CLOSE: begin
          pop = 1'b1;
          if (slot_free) begin
            for (int k = 0; k < cdlp_pkg::FIELD_COUNT; k++) begin
              if (cdlp_pkg::FIELD_CNT_W'(k) == fields_done) begin
                field_store_next[k] = accumulator;
              end
            end
            fields_done_next = fields_done + 1'b1;
            accumulator_next = '0;
          end
        end
        cdlp_pkg::CMD_RESTART: begin
          pop              = 1'b1;
          accumulator_next = '0;
          fields_done_next = '0;
        end
        cdlp_pkg::CMD_TERM: begin
          // A terminator waits until the output register can take its word.
          if (out_free) begin
            pop = 1'b1;
            if (slot_free) begin
              for (int k = 0; k < cdlp_pkg::FIELD_COUNT; k++) begin
                if (cdlp_pkg::FIELD_CNT_W'(k) == fields_done) begin
                  field_store_next[k] = accumulator;
                end
              end
            end
            emit             = line_full;
            accumulator_next = '0;
            fields_done_next = '0;
          end
        end
        default: begin
          pop = 1'b0;
        end
      endcase
    end
  end

  // Result fields; slots beyond the configured count read zero.
  always_comb begin
    for (int k = 0; k < cdlp_pkg::OUT_FIELDS; k++) begin
      shown[k] = '0;
    end
    for (int k = 0; k < cdlp_pkg::SHOWN_FIELDS; k++) begin
      shown[k] = field_store_next[k];
    end
  end

  assign result.value_a = values[0];
  assign result.value_b = values[1];
  assign result.value_c = values[2];
  assign result.value_d = values[3];
  assign result.value_e = values[4];

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      fields_done <= '0;
      for (int k = 0; k < cdlp_pkg::FIELD_COUNT; k++) begin
        field_store[k] <= '0;
      end
    end else begin
      accumulator <= accumulator_next;
      fields_done <= fields_done_next;
      field_store <= field_store_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      values <= shown;
    end
  end

endmodule

// File: rtl/csv_decimal_line_parser_core.sv
// ---------------------------------------------------------------------------
// CSV decimal line parser core
// Parses lines of comma-separated unsigned decimals into five 16-bit values.
// ---------------------------------------------------------------------------
// Usage:
//   The rx channel takes one received character per word (valid/ready). Digits
//   build a value modulo 65536, a comma or a zero byte closes a field, and CR
//   or LF ends the line. A line with at least five closed fields produces one
//   word on the result channel carrying value_a through value_e.
//   Throughput is one character per cycle while the queue is not full. A
//   character runs through the front end into a four-entry command queue;
//   the back end executes one command per cycle, but a terminator waits
//   until the output register is free, which then registers the result word.
//   When the result receiver stalls, the pending result stays in the output
//   register; the back end holds the next terminator at the head of the queue,
//   commands behind it wait, and rx ready drops once the queue is full.
//   A line that reaches the line capacity restarts parsing at the overflow
//   character, which is dropped.
//   Reset (rst, synchronous) empties the queue, clears the line length,
//   accumulator, field count and slots, and drops result valid. No clearing
//   pass is needed; the block accepts characters as soon as reset is released.
// ---------------------------------------------------------------------------
`include "csv_decimal_line_parser_core_defines.svh"

module csv_decimal_line_parser_core (
  input  logic          clk,
  input  logic          rst,
  cdlp_byte_if.sink     rx,
  cdlp_result_if.source result
);

  logic                    push;
  cdlp_pkg::cmd_t          push_cmd;
  logic                    pop;
  cdlp_pkg::cmd_t          head;
  cdlp_pkg::queue_status_t status;

  // Front end: byte classification and line length.
  cdlp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .status   (status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  cdlp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  // Back end: field assembly and result register.
  cdlp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .status (status),
    .pop    (pop),
    .result (result)
  );

  // Checks on the queue and result handoff.
  `CDLP_ASSERT_NOW(a_no_push_when_full, clk, rst, push, !status.full, "command pushed into full queue")
  `CDLP_ASSERT_NOW(a_level_bound, clk, rst, 1'b1, status.level <= cdlp_pkg::QUEUE_LVL_W'(cdlp_pkg::QUEUE_DEPTH), "queue level out of range")
  `CDLP_ASSERT_NOW(a_term_needs_room, clk, rst, pop && (head.op == cdlp_pkg::CMD_TERM), !result.valid || result.ready, "terminator executed while result register busy")
  `CDLP_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push && (status.level == cdlp_pkg::QUEUE_LVL_W'(1)), status.empty, "queue not empty after last pop")

endmodule
